// ----- hw/rtl/skal3_pkg.sv -----
// Shared types and constants for the three-axis scalar Kalman smoother.
// Used by skal3_div, skal3_mul and scalar_kalman_three_axis_top.
package skal3_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int SAMP_W    = 16;
    localparam int DATA_W    = 48;   // three packed samples, no padding needed
    localparam int COV_W     = 32;   // unsigned Q8.24
    localparam int DEN_W     = 33;   // Pn + R at full width
    localparam int REM_W     = 34;   // divider partial remainder
    localparam int FRAC_W    = 24;
    localparam int K_W       = 25;   // gain 0 .. 2^24
    localparam int K_CNT_W   = 5;    // counts K_W quotient bits
    localparam int EST_W     = 40;   // signed Q24.16
    localparam int DIFF_W    = 41;
    localparam int MAG_W     = 33;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 42;
    localparam int ACC_W     = 58;
    localparam int HALF_W    = 16;
    localparam int MSTEP_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [K_W-1:0]   ONE_Q24 = K_W'(25'h100_0000);
    localparam logic [COV_W-1:0] P_RESET = 32'd335544;
    localparam logic [COV_W-1:0] Q_RESET = 32'd16777;
    localparam logic [COV_W-1:0] R_RESET = 32'd33554432;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    // multiply schedule: gain times error halves, then (1-K) times Pn halves
    localparam logic [MSTEP_W-1:0] MS_CORR_LO = 3'd0;
    localparam logic [MSTEP_W-1:0] MS_CORR_HI = 3'd1;
    localparam logic [MSTEP_W-1:0] MS_COV_LO  = 3'd2;
    localparam logic [MSTEP_W-1:0] MS_COV_HI  = 3'd3;
    localparam logic [MSTEP_W-1:0] MS_DRAIN   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            start;
        logic [COV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

// ----- hw/rtl/skal3_div.sv -----
// Restoring divider for the Kalman gain: floor(num * 2^24 / den), one bit a cycle.
// Depends on skal3_pkg.
module skal3_div
    import skal3_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             done,
    output logic [K_W-1:0]   quot
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [K_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [K_W-1:0]     q_reg, q_next;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // first step compares the plain numerator: it yields the 2^24 bit
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = REM_W'(req.num);
            den_next  = req.den;
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - REM_W'(den_reg)) : trial;
            q_next   = {q_reg[K_W-2:0], fits};
            cnt_next = cnt_reg + K_CNT_W'(1);
            if (cnt_reg == K_CNT_W'(K_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    // zero denominator gives zero gain
    assign quot = (den_reg == '0) ? '0 : q_reg;

endmodule

// ----- hw/rtl/skal3_mul.sv -----
// Shared 25x17 unsigned multiplier with registered product.
// Depends on skal3_pkg.
module skal3_mul
    import skal3_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg, prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/scalar_kalman_three_axis_top.sv -----
// Top level of the three-axis scalar Kalman smoother: sequencer, state and config.
// Depends on skal3_pkg, skal3_div and skal3_mul.
//
// Usage:
//   s_ channel takes one beat of three signed 16-bit accelerometer samples.
//   m_ channel returns one beat of three filtered samples, each the axis
//   estimate truncated toward zero and saturated to 16 bits.
//   cfg_ channel writes Q (index 0) or R (index 1), unsigned Q8.24; cfg_ready
//   is always high. Other indexes are ignored. Write only while idle.
// Sequence:
//   The axes run one after another through a shared serial divider and a
//   shared 25x17 multiplier. Per axis: a prepare state, the divider (25
//   quotient bits), the multiplier halves and drain, then an update state.
//   s_tready is high only in idle, so a new beat is taken only once the
//   last result has moved into the output register.
// Reset (aresetn low, synchronous): covariances to 0.02, estimates to zero,
//   Q to 0.001, R to 2.0, no beat pending.
// Stall: a finished result is held in the output register; the block takes the
//   next input beat meanwhile and, if that one finishes before the receiver
//   takes the old beat, waits with the new result until it does.
module scalar_kalman_three_axis_top
    import skal3_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // filtered_x[15:0], filtered_y[31:16],
                                            // filtered_z[47:32]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COV_W-1:0]     cfg_data
);

    state_t               state_reg, state_next;
    logic [AXIS_W-1:0]    axis_reg, axis_next;
    logic [DATA_W-1:0]    samp_reg, samp_next;
    logic [DATA_W-1:0]    res_reg, res_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COV_W-1:0]     q_noise_reg, q_noise_next;
    logic [COV_W-1:0]     r_noise_reg, r_noise_next;
    logic [COV_W-1:0]     cov_reg [AXES];
    logic [EST_W-1:0]     est_reg [AXES];
    logic [COV_W-1:0]     pn_reg, pn_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [MSTEP_W-1:0]   mstep_reg, mstep_next;
    logic [ACC_W-1:0]     corr_acc_reg, corr_acc_next;
    logic [ACC_W-1:0]     cov_acc_reg, cov_acc_next;

    logic                 in_beat;
    logic                 out_load;
    logic                 wr_state;
    logic [COV_W:0]       pn_sum;
    logic [COV_W-1:0]     pn_sat;
    logic [DEN_W-1:0]     den;
    logic [SAMP_W-1:0]    samp_axis;
    logic [EST_W-1:0]     x_scaled;
    logic [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]    diff_abs;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod;
    logic [ACC_W-1:0]     prod_ext;
    logic [EST_W-1:0]     corr;
    logic [EST_W-1:0]     est_new;
    logic [COV_W-1:0]     cov_new;
    logic [EST_W-1:0]     est_abs;
    logic [EST_W-HALF_W-1:0] est_int;
    logic [SAMP_W-1:0]    filt;
    div_req_t             div_req;
    logic                 div_done;
    logic [K_W-1:0]       div_quot;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign wr_state  = (state_reg == ST_UPD);

    // prediction and innovation for the current axis
    assign pn_sum    = {1'b0, cov_reg[axis_reg]} + {1'b0, q_noise_reg};
    assign pn_sat    = pn_sum[COV_W] ? '1 : pn_sum[COV_W-1:0];
    assign den       = DEN_W'(pn_sat) + DEN_W'(r_noise_reg);
    assign samp_axis = samp_reg[axis_reg*SAMP_W +: SAMP_W];
    assign x_scaled  = {{(EST_W-SAMP_W-HALF_W){samp_axis[SAMP_W-1]}}, samp_axis,
                        {HALF_W{1'b0}}};
    assign diff      = {x_scaled[EST_W-1], x_scaled} - {est_reg[axis_reg][EST_W-1],
                        est_reg[axis_reg]};
    assign diff_abs  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    assign div_req.start = (state_reg == ST_PREP);
    assign div_req.num   = pn_sat;
    assign div_req.den   = den;

    skal3_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // operand schedule for the shared multiplier
    always_comb begin
        mul_a = (mstep_reg == MS_CORR_LO || mstep_reg == MS_CORR_HI) ? k_reg
                                                                      : (ONE_Q24 - k_reg);
        case (mstep_reg)
            MS_CORR_LO: mul_b = MUL_B_W'(mag_reg[HALF_W-1:0]);
            MS_CORR_HI: mul_b = mag_reg[MAG_W-1:HALF_W];
            MS_COV_LO:  mul_b = MUL_B_W'(pn_reg[HALF_W-1:0]);
            MS_COV_HI:  mul_b = MUL_B_W'(pn_reg[COV_W-1:HALF_W]);
            default:    mul_b = '0;
        endcase
    end

    skal3_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_ext = ACC_W'(prod);

    // correction and write-back
    assign corr    = EST_W'(corr_acc_reg[ACC_W-1:FRAC_W]);
    assign est_new = neg_reg ? (est_reg[axis_reg] - corr) : (est_reg[axis_reg] + corr);
    assign cov_new = cov_acc_reg[FRAC_W+COV_W-1:FRAC_W];
    assign est_abs = est_new[EST_W-1] ? (~est_new + EST_W'(1)) : est_new;
    assign est_int = est_abs[EST_W-1:HALF_W];

    always_comb begin
        if (!est_new[EST_W-1]) begin
            filt = (est_int > (EST_W-HALF_W)'(32767)) ? 16'sh7FFF : est_int[SAMP_W-1:0];
        end else begin
            filt = (est_int > (EST_W-HALF_W)'(32768)) ? 16'h8000
                                                      : (~est_int[SAMP_W-1:0] + 16'd1);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_beat) state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MUL;
            ST_MUL:  if (mstep_reg == MS_DRAIN) state_next = ST_UPD;
            ST_UPD:  state_next = (axis_reg == AXIS_W'(AXES - 1)) ? ST_DONE : ST_PREP;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and output registers
    always_comb begin
        axis_next      = axis_reg;
        samp_next      = samp_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        q_noise_next   = q_noise_reg;
        r_noise_next   = r_noise_reg;
        pn_next        = pn_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        mstep_next     = mstep_reg;
        corr_acc_next  = corr_acc_reg;
        cov_acc_next   = cov_acc_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PROCESS_NOISE:     q_noise_next = cfg_data;
                CFG_MEASUREMENT_NOISE: r_noise_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    samp_next = s_tdata;
                    axis_next = '0;
                end
            end
            ST_PREP: begin
                pn_next  = pn_sat;
                neg_next = diff[DIFF_W-1];
                mag_next = diff_abs[MAG_W-1:0];
            end
            ST_DIV: begin
                k_next     = div_quot;
                mstep_next = MS_CORR_LO;
            end
            ST_MUL: begin
                mstep_next = mstep_reg + MSTEP_W'(1);
                // product of the previous step lands now
                case (mstep_reg)
                    MS_CORR_HI: corr_acc_next = prod_ext;
                    MS_COV_LO:  corr_acc_next = corr_acc_reg + (prod_ext << HALF_W);
                    MS_COV_HI:  cov_acc_next  = prod_ext;
                    MS_DRAIN:   cov_acc_next  = cov_acc_reg + (prod_ext << HALF_W);
                    default: ;
                endcase
            end
            ST_UPD: begin
                res_next[axis_reg*SAMP_W +: SAMP_W] = filt;
                // wrap after the last axis so the index stays in range
                axis_next = (axis_reg == AXIS_W'(AXES - 1)) ? '0 : axis_reg + AXIS_W'(1);
            end
            ST_DONE: begin
                if (out_load) begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            q_noise_reg   <= Q_RESET;
            r_noise_reg   <= R_RESET;
            mstep_reg     <= '0;
            for (int i = 0; i < AXES; i++) begin
                cov_reg[i] <= P_RESET;
                est_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            q_noise_reg   <= q_noise_next;
            r_noise_reg   <= r_noise_next;
            mstep_reg     <= mstep_next;
            if (wr_state) begin
                cov_reg[axis_reg] <= cov_new;
                est_reg[axis_reg] <= est_new;
            end
        end
        samp_reg     <= samp_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        pn_reg       <= pn_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        k_reg        <= k_next;
        corr_acc_reg <= corr_acc_next;
        cov_acc_reg  <= cov_acc_next;
    end

    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (k_reg <= ONE_Q24))
        else $error("gain above one");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (axis_reg <= AXIS_W'(AXES - 1)))
        else $error("axis index out of range");

    a_cov_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (cov_acc_reg[ACC_W-1:FRAC_W+COV_W] == '0))
        else $error("covariance product overflows");

    a_output_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without finishing all axes");

endmodule

// ----- tb/tb_scalar_kalman_three_axis_top.sv -----
// Self-checking testbench for scalar_kalman_three_axis_top: a directed table, then random
// batches under several idle/stall mixes, checked beat by beat against a filter predictor.
// Depends on skal3_pkg and the scalar_kalman_three_axis_top RTL.
module tb_scalar_kalman_three_axis_top;
    import skal3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
    localparam logic [63:0]          GAIN_ONE      = 64'(ONE_Q24);
    localparam int                   DRAIN_CYCLES  = 120;
    localparam int                   BATCHES       = 12;
    localparam int                   BATCH_BEATS   = 58;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } axis_triple_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [COV_W-1:0]      value;
        logic signed [15:0]    sx;
        logic signed [15:0]    sy;
        logic signed [15:0]    sz;
        logic                  typed;
        logic signed [15:0]    ex;
        logic signed [15:0]    ey;
        logic signed [15:0]    ez;
    } step_row_t;

    localparam int DIR_ROWS = 27;

    // kind, reg index, reg value, sample x/y/z, typed expectation?, expected x/y/z
    step_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
          1'b1, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd32767, 16'sh8000, 16'sd1,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, -16'sd1, 16'sd32767, 16'sh8000,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sh5555, 16'shAAAA, 16'sh00FF,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'shAAAA, 16'sh5555, 16'shFF00,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        // R = 0 and Q at max: Pn saturates, gain is exactly one, estimate jumps to sample
        '{ROW_WRITE, CFG_MEASUREMENT_NOISE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd32767, 16'sh8000, -16'sd1,
          1'b1, 16'sd32767, 16'sh8000, -16'sd1},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sh8000, 16'sd32767, 16'sd0,
          1'b1, 16'sh8000, 16'sd32767, 16'sd0},
        // covariance is now zero; Q = 0 makes the gain denominator zero, so nothing moves
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd1234, -16'sd5, 16'sd100,
          1'b1, 16'sh8000, 16'sd32767, 16'sd0},
        '{ROW_WRITE, CFG_UNUSED_LO, 32'h1234_5678, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_UNUSED_HI, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd32767, 16'sd32767, 16'sd32767,
          1'b1, 16'sh8000, 16'sd32767, 16'sd0},
        // Pn = 1 over a 2^32 denominator rounds the gain down to zero
        '{ROW_WRITE, CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'd1, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd0, 16'sd0, 16'sd0,
          1'b1, 16'sh8000, 16'sd32767, 16'sd0},
        '{ROW_WRITE, CFG_PROCESS_NOISE, Q_RESET, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_MEASUREMENT_NOISE, R_RESET, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd100, -16'sd100, 16'sd32767,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd100, -16'sd100, 16'sd32767,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sh8000, 16'sd32767, 16'sh8000,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'h0800_0000, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_WRITE, CFG_MEASUREMENT_NOISE, 32'd1, 16'sd0, 16'sd0, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd7, -16'sd7, 16'sd12345,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, 16'sd32767, 16'sh8000, 16'sd0,
          1'b0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_SAMPLE, CFG_PROCESS_NOISE, 32'd0, -16'sd3, 16'sd3, -16'sd32767,
          1'b0, 16'sd0, 16'sd0, 16'sd0}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // filtered_x[15:0], filtered_y[31:16],
                                             // filtered_z[47:32]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COV_W-1:0]      cfg_data  = '0;

    // predictor state and register copies
    logic [COV_W-1:0]      q_noise;
    logic [COV_W-1:0]      r_noise;
    logic [COV_W-1:0]      cov_st [AXES];
    longint                est_st [AXES];

    axis_triple_t          filtered_q [$];
    axis_triple_t          last_sent = '0;
    int                    mismatches = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    scalar_kalman_three_axis_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("scalar_kalman_three_axis_top verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // One Kalman step on one axis; updates the predictor state, returns the int16 output.
    function automatic logic signed [15:0] update_axis_estimate(input int a,
                                                                input logic signed [15:0] smp);
        logic [63:0] pn;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] corr;
        longint      x;
        longint      diff;
        longint      e;
        longint      q;
        pn = 64'(cov_st[a]) + 64'(q_noise);
        if (pn > 64'hFFFF_FFFF) pn = 64'hFFFF_FFFF;
        den = pn + 64'(r_noise);
        gain = (den == 64'd0) ? 64'd0 : ((pn << 24) / den);
        if (gain > GAIN_ONE) gain = GAIN_ONE;
        x = longint'(smp) * 65536;
        e = est_st[a];
        diff = x - e;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        corr = (gain * mag) >> 24;
        if (diff < 0) e = e - longint'(corr);
        else e = e + longint'(corr);
        est_st[a] = e;
        cov_st[a] = 32'(((GAIN_ONE - gain) * pn) >> 24);
        // truncate toward zero, then saturate
        if (e >= 0) q = e >>> 16;
        else q = -((-e) >>> 16);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    function automatic axis_triple_t predict_filtered(input axis_triple_t smp);
        axis_triple_t r;
        r.x = update_axis_estimate(0, smp.x);
        r.y = update_axis_estimate(1, smp.y);
        r.z = update_axis_estimate(2, smp.z);
        return r;
    endfunction

    task automatic send_sample(input axis_triple_t smp, input logic typed,
                               input axis_triple_t want);
        axis_triple_t pred;
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        pred = predict_filtered(smp);
        filtered_q.push_back(typed ? want : pred);
        last_sent = smp;
        // drop valid so the beat is not taken twice
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COV_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_PROCESS_NOISE) q_noise = value;
        else if (idx == CFG_MEASUREMENT_NOISE) r_noise = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // hold until every outstanding result has come back
    task automatic wait_results_drained();
        while (filtered_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [COV_W-1:0] pick_noise(input logic [COV_W-1:0] nominal);
        case ($urandom_range(4))
            0: return nominal;
            1: return '0;
            2: return 32'hFFFF_FFFF;
            3: return COV_W'($urandom_range(0, 32'h0400_0000));
            default: return COV_W'($urandom);
        endcase
    endfunction

    // Noisy readings around a level most often, so the filter settles; some full-range and
    // extreme values, some repeats.
    function automatic logic signed [15:0] pick_axis(input logic signed [15:0] level,
                                                     input logic signed [15:0] prev);
        int r;
        r = $urandom_range(99);
        if (r < 30) return 16'($urandom);
        if (r < 45) begin
            case ($urandom_range(3))
                0: return 16'sd32767;
                1: return 16'sh8000;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        if (r < 90) return level + 16'(int'($urandom_range(0, 64)) - 32);
        return prev;
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        axis_triple_t want;
        string        names [3];
        names = '{"filtered_x", "filtered_y", "filtered_z"};
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("result beat %h with none outstanding", m_tdata));
            end else begin
                want = filtered_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[16*i +: 16] !== want[16*i +: 16])
                        report_mismatch($sformatf("%s got %0d expected %0d", names[i],
                                        $signed(m_tdata[16*i +: 16]),
                                        $signed(want[16*i +: 16])));
                end
            end
        end
    end

    initial begin
        axis_triple_t smp;
        axis_triple_t want;
        axis_triple_t level;
        q_noise = Q_RESET;
        r_noise = R_RESET;
        for (int a = 0; a < AXES; a++) begin
            cov_st[a] = P_RESET;
            est_st[a] = 0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_results_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                smp  = '{z: dir_rows[i].sz, y: dir_rows[i].sy, x: dir_rows[i].sx};
                want = '{z: dir_rows[i].ez, y: dir_rows[i].ey, x: dir_rows[i].ex};
                send_sample(smp, dir_rows[i].typed, want);
            end
        end

        for (int b = 0; b < BATCHES; b++) begin
            wait_results_drained();
            case (b % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            write_reg(CFG_PROCESS_NOISE, pick_noise(Q_RESET));
            write_reg(CFG_MEASUREMENT_NOISE, pick_noise(R_RESET));
            level = axis_triple_t'($urandom_range(0, 32'hFFFF) |
                                   (48'($urandom) << 16));
            for (int n = 0; n < BATCH_BEATS; n++) begin
                smp.x = pick_axis(level.x, last_sent.x);
                smp.y = pick_axis(level.y, last_sent.y);
                smp.z = pick_axis(level.z, last_sent.z);
                send_sample(smp, 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("scalar_kalman_three_axis_top verification clean");
        end else begin
            $display("scalar_kalman_three_axis_top verification failed");
        end
        $finish;
    end

endmodule
